### hw/rtl/dopr_pkg.sv
// Shared types and constants for the dual overwriting packet ring.
// Used by dopr_ring and dual_overwriting_packet_ring_core; no dependencies.
package dopr_pkg;

   localparam int DEF_COORD_DEPTH  = 16;
   localparam int DEF_UPLINK_DEPTH = 16;
   localparam int DEF_PACKET_BITS  = 64;

   localparam int PACKET_PORT_BITS = 64;
   localparam int COUNT_BITS       = 5;
   localparam int POS_BITS         = 4;

   typedef enum logic [1:0] {
      CMD_PUSH = 2'd0,
      CMD_POP  = 2'd1,
      CMD_PEEK = 2'd2
   } cmd_type;

   typedef struct packed {
      logic                  head_valid;
      logic                  overflowed;
      logic [COUNT_BITS-1:0] fill_count;
      logic [POS_BITS-1:0]   read_position;
      logic [POS_BITS-1:0]   write_position;
   } status_type;

endpackage

### hw/rtl/dopr_ring.sv
// One overwriting circular packet queue: pointers, flags and packet memory.
// Depends on dopr_pkg for the command codes and the status struct.
module dopr_ring #(
   parameter int DEPTH       = dopr_pkg::DEF_COORD_DEPTH,
   parameter int PACKET_BITS = dopr_pkg::DEF_PACKET_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   op_valid,
   input  dopr_pkg::cmd_type      cmd,
   input  logic [PACKET_BITS-1:0] packet,
   input  logic                   report_overflow,
   output dopr_pkg::status_type   status,
   output logic [PACKET_BITS-1:0] rdata_ff
);
   import dopr_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [PACKET_BITS-1:0] mem_ff [DEPTH];

   logic [PW-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic          empty_ff, empty_in, ovf_ff, ovf_in;
   logic [PW-1:0] rd_next, wr_next;
   logic          full;
   logic [CW-1:0] count;
   logic [CW+COUNT_BITS-1:0] count_wide;
   logic [PW+POS_BITS-1:0]   rd_wide, wr_wide;

   assign rd_next = (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
   assign wr_next = (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
   assign full    = !empty_ff && (rd_ff == wr_ff);

   always_comb begin
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      empty_in = empty_ff;
      ovf_in   = ovf_ff;
      status.head_valid = 1'b0;
      status.overflowed = 1'b0;
      case (cmd)
         CMD_PUSH: begin
            wr_in    = wr_next;
            empty_in = 1'b0;
            if (full) begin
               rd_in = rd_next;
            end
            if (full && report_overflow) begin
               ovf_in = 1'b1;
            end
         end
         CMD_POP: begin
            if (!empty_ff) begin
               status.head_valid = 1'b1;
               status.overflowed = ovf_ff;
               rd_in    = rd_next;
               ovf_in   = 1'b0;
               empty_in = (rd_next == wr_ff);
            end
         end
         CMD_PEEK: begin
            if (empty_ff) begin
               ovf_in = 1'b0;
            end else begin
               status.head_valid = 1'b1;
               status.overflowed = ovf_ff;
            end
         end
         default: begin
         end
      endcase

      // count after the operation
      if (empty_in) begin
         count = '0;
      end else if (rd_in < wr_in) begin
         count = CW'(wr_in) - CW'(rd_in);
      end else begin
         count = DEPTH_C - (CW'(rd_in) - CW'(wr_in));
      end
      count_wide = {{COUNT_BITS{1'b0}}, count};
      rd_wide    = {{POS_BITS{1'b0}}, rd_in};
      wr_wide    = {{POS_BITS{1'b0}}, wr_in};
      status.fill_count     = count_wide[COUNT_BITS-1:0];
      status.read_position  = rd_wide[POS_BITS-1:0];
      status.write_position = wr_wide[POS_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         empty_ff <= 1'b1;
         ovf_ff   <= 1'b0;
      end else if (op_valid) begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         empty_ff <= empty_in;
         ovf_ff   <= ovf_in;
      end
   end

   // packet memory: write at the write pointer, read the head every request
   always_ff @(posedge clock) begin
      if (op_valid && cmd == CMD_PUSH) begin
         mem_ff[wr_ff] <= packet;
      end
   end

   always_ff @(posedge clock) begin
      if (op_valid) begin
         rdata_ff <= mem_ff[rd_ff];
      end
   end

endmodule

### hw/rtl/dual_overwriting_packet_ring_core.sv
// Top level of the dual overwriting packet ring: two queues, result pipeline.
// Depends on dopr_pkg and dopr_ring.
//
//  channel  dir  handshake            payload
//  req_     in   req_valid/req_stall  cmd, queue_select, packet_word, report_overflow
//  rsp_     out  rsp_valid/rsp_stall  head_valid, head_packet, overflowed,
//                                     fill_count, read_position, write_position
//
// One request per cycle while req_stall is low. A response is held in the stage-1
// register and the packet memory read register, then in the output register.
// Pointers and flags update at the accepting edge, so the next request sees them.
// Reset is synchronous; both queues come out empty with pointers at zero.
// A stalled response holds the pipeline; req_stall rises only when both stages are full.
module dual_overwriting_packet_ring_core #(
   parameter int COORD_DEPTH  = dopr_pkg::DEF_COORD_DEPTH,
   parameter int UPLINK_DEPTH = dopr_pkg::DEF_UPLINK_DEPTH,
   parameter int PACKET_BITS  = dopr_pkg::DEF_PACKET_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_cmd,
   input  logic                                  req_queue_select,
   input  logic [dopr_pkg::PACKET_PORT_BITS-1:0] req_packet_word,
   input  logic                                  req_report_overflow,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_head_valid,
   output logic [dopr_pkg::PACKET_PORT_BITS-1:0] rsp_head_packet,
   output logic                                  rsp_overflowed,
   output logic [dopr_pkg::COUNT_BITS-1:0]       rsp_fill_count,
   output logic [dopr_pkg::POS_BITS-1:0]         rsp_read_position,
   output logic [dopr_pkg::POS_BITS-1:0]         rsp_write_position
);
   import dopr_pkg::*;

   logic       req_accept, out_adv;
   cmd_type    cmd;
   status_type coord_status, uplink_status;
   logic [PACKET_BITS-1:0] coord_rdata, uplink_rdata, head_rdata;
   logic [PACKET_PORT_BITS-1:0] head_ext;

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_sel_ff;
   status_type s1_status_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   status_type                  rsp_status_ff;
   logic [PACKET_PORT_BITS-1:0] rsp_packet_ff;

   assign cmd        = cmd_type'(req_cmd);
   assign out_adv    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !out_adv;
   assign req_accept = req_valid && !req_stall;

   dopr_ring #(
      .DEPTH       (COORD_DEPTH),
      .PACKET_BITS (PACKET_BITS)
   ) u_coord (
      .clock           (clock),
      .reset           (reset),
      .op_valid        (req_accept && !req_queue_select),
      .cmd             (cmd),
      .packet          (req_packet_word[PACKET_BITS-1:0]),
      .report_overflow (req_report_overflow),
      .status          (coord_status),
      .rdata_ff        (coord_rdata)
   );

   dopr_ring #(
      .DEPTH       (UPLINK_DEPTH),
      .PACKET_BITS (PACKET_BITS)
   ) u_uplink (
      .clock           (clock),
      .reset           (reset),
      .op_valid        (req_accept && req_queue_select),
      .cmd             (cmd),
      .packet          (req_packet_word[PACKET_BITS-1:0]),
      .report_overflow (req_report_overflow),
      .status          (uplink_status),
      .rdata_ff        (uplink_rdata)
   );

   assign s1_valid_in  = req_accept || (s1_valid_ff && !out_adv);
   assign rsp_valid_in = s1_valid_ff || (rsp_valid_ff && rsp_stall);
   assign head_rdata   = s1_sel_ff ? uplink_rdata : coord_rdata;

   always_comb begin
      head_ext = '0;
      if (s1_status_ff.head_valid) begin
         head_ext[PACKET_BITS-1:0] = head_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sel_ff    <= req_queue_select;
         s1_status_ff <= req_queue_select ? uplink_status : coord_status;
      end
      if (s1_valid_ff && out_adv) begin
         rsp_status_ff <= s1_status_ff;
         rsp_packet_ff <= head_ext;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_head_valid     = rsp_status_ff.head_valid;
   assign rsp_head_packet    = rsp_packet_ff;
   assign rsp_overflowed     = rsp_status_ff.overflowed;
   assign rsp_fill_count     = rsp_status_ff.fill_count;
   assign rsp_read_position  = rsp_status_ff.read_position;
   assign rsp_write_position = rsp_status_ff.write_position;

   a_no_head_is_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_head_valid |-> rsp_head_packet == '0 && !rsp_overflowed)
      else $error("response without head carries data or overflow");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request lost before the response stage");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_adv |=> s1_valid_ff && $stable(s1_status_ff) && $stable(s1_sel_ff))
      else $error("pending request changed while the response was stalled");

endmodule
